[rtl/pdb_pkg.sv]
// Shared types and constants of the two-axis PD balance controller.
// Used by pdb_mul, pdb_div and two_axis_pd_balance_with_estop; no dependencies.
package pdb_pkg;

    // Controller constants
    localparam int RATE_REF_DEGS     = 180;
    localparam int LEAN_DEG_PER_UNIT = 0;
    localparam int RAD2DEG_Q16       = 3754936;   // 180/pi in Q16
    localparam int RATE_SHIFT        = 20;        // Q4.12 * Q16 -> Q12.8
    localparam int CMAX_LIMIT        = 16384;

    // Field widths
    localparam int ANGLE_W = 17;
    localparam int RATE_W  = 16;
    localparam int VEL_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int THR_W   = 16;
    localparam int DB_W    = 12;
    localparam int CMAX_W  = 15;
    localparam int CORR_W  = 16;
    localparam int DPS_W   = 20;                  // deg/s display, Q12.8

    // Shared multiplier
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Datapath widths
    localparam int ERR_W = 24;                    // angle error, Q.14 degrees
    localparam int KPS_W = 29;                    // kp * 4 * RATE_REF
    localparam int KDT_W = 33;                    // kd * threshold
    localparam int NUM_W = 53;                    // PD numerator
    localparam int DEN_W = 33;                    // 64 * threshold * RATE_REF
    localparam int QUO_W = 16;                    // saturated quotient

    // Constant multiplier operands
    localparam logic signed [MUL_B_W-1:0] B_RAD2DEG   = MUL_B_W'(RAD2DEG_Q16);
    localparam logic signed [MUL_B_W-1:0] B_LEAN      = MUL_B_W'(LEAN_DEG_PER_UNIT);
    localparam logic signed [MUL_B_W-1:0] B_KP_SCALE  = MUL_B_W'(4 * RATE_REF_DEGS);
    localparam logic signed [MUL_B_W-1:0] B_DEN_SCALE = MUL_B_W'(64 * RATE_REF_DEGS);

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESTOP_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KP_PITCH        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KD_PITCH        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KP_ROLL         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KD_ROLL         = 3'd7;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PR,
        ST_RR,
        ST_LEAN,
        ST_DEN,
        ST_DB,
        ST_AX_KP,
        ST_AX_KD,
        ST_AX_E,
        ST_AX_R,
        ST_AX_SUM,
        ST_AX_DIV,
        ST_AX_WAIT,
        ST_FINISH
    } state_t;

endpackage

[rtl/two_axis_pd_balance_with_estop.sv]
// Two-axis PD balance controller with latching tilt e-stop.
// Invalid items go straight to the output register; disabled or latched items
// stop after the display products; otherwise two 16-step divisions in pdb_div
// dominate the work, plus one pass per product through the shared pdb_mul. One item
// at a time: the next item is taken once the result has moved to the output register.
// Reset (aresetn low, synchronous): e-stop latch clear, configuration registers at defaults.
module two_axis_pd_balance_with_estop import pdb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pitch_angle, roll_angle, pitch_rate, roll_rate, forward_velocity, zero pad
    input  logic [87:0]           s_axis_tdata,
    // imu_valid
    input  logic [0:0]            s_axis_tuser,
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pitch_display, pitch_rate_display, roll_display, correction_y,
    // correction_x, zero pad
    output logic [87:0]           m_axis_tdata,
    // result_valid, enabled_flag, estop_flag
    output logic [2:0]            m_axis_tuser
);

    // configuration registers
    logic                     balance_enable_reg;
    logic [THR_W-1:0]         estop_threshold_reg;
    logic [DB_W-1:0]          deadband_reg;
    logic [CMAX_W-1:0]        correction_max_reg;
    logic signed [GAIN_W-1:0] kp_pitch_reg;
    logic signed [GAIN_W-1:0] kd_pitch_reg;
    logic signed [GAIN_W-1:0] kp_roll_reg;
    logic signed [GAIN_W-1:0] kd_roll_reg;

    // control state
    state_t state_reg, state_next;
    logic   estop_latch_reg;
    logic   run_reg;
    logic   axis_reg;
    logic   m_valid_reg;

    // item and datapath registers
    logic                      imu_valid_reg;
    logic signed [ANGLE_W-1:0] pitch_reg;
    logic signed [ANGLE_W-1:0] roll_reg;
    logic signed [RATE_W-1:0]  prate_reg;
    logic signed [RATE_W-1:0]  rrate_reg;
    logic signed [VEL_W-1:0]   vel_reg;
    logic signed [DPS_W-1:0]   prd_reg;
    logic signed [DPS_W-1:0]   rrd_reg;
    logic signed [ERR_W-1:0]   perr_reg;
    logic signed [ERR_W-1:0]   rerr_reg;
    logic [DEN_W-1:0]          den_reg;
    logic signed [KPS_W-1:0]   t1_reg;
    logic signed [KDT_W-1:0]   t2_reg;
    logic signed [NUM_W-1:0]   acc_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic                      neg_reg;
    logic signed [CORR_W-1:0]  cy_reg;
    logic signed [CORR_W-1:0]  cx_reg;
    logic [87:0]               m_data_reg;
    logic [2:0]                m_user_reg;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic                      div_start;
    logic [NUM_W-1:0]          div_num;
    logic                      div_done;
    logic [QUO_W-1:0]          div_quo;

    // combinational helpers
    logic [THR_W-1:0]          thr_eff;
    logic [CMAX_W-1:0]         cmax_eff;
    logic [ANGLE_W-1:0]        ap;
    logic [ANGLE_W-1:0]        ar;
    logic [19:0]               five_ap;
    logic [19:0]               five_ar;
    logic [19:0]               four_thr;
    logic                      latch_set;
    logic                      latch_next;
    logic signed [GAIN_W-1:0]  kp_sel;
    logic signed [GAIN_W-1:0]  kd_sel;
    logic signed [ERR_W-1:0]   err_sel;
    logic signed [DPS_W-1:0]   rate_sel;
    logic [NUM_W-1:0]          num_mag;
    logic [CMAX_W-1:0]         q_clamped;
    logic signed [CORR_W-1:0]  corr;
    logic                      out_free;
    logic                      accept;

    localparam logic [MUL_P_W-1:0] ROUND_HALF = MUL_P_W'(1) << (RATE_SHIFT - 1);

    // Q4.12 rad/s times 180/pi in Q16, rounded half away from zero to Q12.8
    function automatic logic [DPS_W-1:0] rate_round(input logic signed [MUL_P_W-1:0] p);
        logic [MUL_P_W-1:0] mag;
        logic [MUL_P_W-1:0] q;
        logic [DPS_W-1:0]   qs;
        mag = p[MUL_P_W-1] ? MUL_P_W'(-p) : MUL_P_W'(p);
        q   = (mag + ROUND_HALF) >> RATE_SHIFT;
        qs  = q[DPS_W-1:0];
        return p[MUL_P_W-1] ? (~qs + 1'b1) : qs;
    endfunction

    // zero the error inside the deadband
    function automatic logic [ERR_W-1:0] apply_db(input logic signed [ERR_W-1:0] e,
                                                  input logic [DB_W-1:0] db);
        logic [ERR_W-1:0] mag;
        mag = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
        return (mag < ERR_W'({db, 6'b0})) ? '0 : e;
    endfunction

    pdb_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    pdb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            balance_enable_reg  <= 1'b0;
            estop_threshold_reg <= 16'd7680;
            deadband_reg        <= 12'd256;
            correction_max_reg  <= 15'd11469;
            kp_pitch_reg        <= '0;
            kd_pitch_reg        <= '0;
            kp_roll_reg         <= '0;
            kd_roll_reg         <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BALANCE_ENABLE:  balance_enable_reg  <= cfg_data[0];
                REG_ESTOP_THRESHOLD: estop_threshold_reg <= cfg_data[THR_W-1:0];
                REG_DEADBAND:        deadband_reg        <= cfg_data[DB_W-1:0];
                REG_CORRECTION_MAX:  correction_max_reg  <= cfg_data[CMAX_W-1:0];
                REG_KP_PITCH:        kp_pitch_reg        <= cfg_data[GAIN_W-1:0];
                REG_KD_PITCH:        kd_pitch_reg        <= cfg_data[GAIN_W-1:0];
                REG_KP_ROLL:         kp_roll_reg         <= cfg_data[GAIN_W-1:0];
                REG_KD_ROLL:         kd_roll_reg         <= cfg_data[GAIN_W-1:0];
                default:             ;
            endcase
        end
    end

    // helpers
    assign thr_eff  = (estop_threshold_reg == '0) ? THR_W'(1) : estop_threshold_reg;
    assign cmax_eff = (correction_max_reg > CMAX_W'(CMAX_LIMIT)) ? CMAX_W'(CMAX_LIMIT)
                                                                 : correction_max_reg;

    assign ap       = pitch_reg[ANGLE_W-1] ? ANGLE_W'(-pitch_reg) : ANGLE_W'(pitch_reg);
    assign ar       = roll_reg[ANGLE_W-1]  ? ANGLE_W'(-roll_reg)  : ANGLE_W'(roll_reg);
    assign five_ap  = ({3'b0, ap} << 2) + {3'b0, ap};
    assign five_ar  = ({3'b0, ar} << 2) + {3'b0, ar};
    assign four_thr = {2'b0, thr_eff, 2'b0};

    // set on either axis over the limit, clear once both are under 80%
    assign latch_set  = (ap > ANGLE_W'(thr_eff)) || (ar > ANGLE_W'(thr_eff));
    assign latch_next = (estop_latch_reg || latch_set)
                        && !((five_ap < four_thr) && (five_ar < four_thr));

    assign kp_sel   = axis_reg ? kp_roll_reg : kp_pitch_reg;
    assign kd_sel   = axis_reg ? kd_roll_reg : kd_pitch_reg;
    assign err_sel  = axis_reg ? rerr_reg : perr_reg;
    assign rate_sel = axis_reg ? rrd_reg : prd_reg;

    assign num_mag  = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign div_num  = num_mag + NUM_W'(den_reg >> 1);

    assign q_clamped = (div_quo > QUO_W'(cmax_eff)) ? cmax_eff : div_quo[CMAX_W-1:0];
    // correction is the negated rounded quotient
    assign corr      = neg_reg ? CORR_W'({1'b0, q_clamped}) : -CORR_W'({1'b0, q_clamped});

    assign out_free = !m_valid_reg || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    state_next = s_axis_tuser[0] ? ST_PR : ST_FINISH;
                end
            end
            ST_PR: begin
                mul_a      = MUL_A_W'(prate_reg);
                mul_b      = B_RAD2DEG;
                state_next = ST_RR;
            end
            ST_RR: begin
                mul_a      = MUL_A_W'(rrate_reg);
                mul_b      = B_RAD2DEG;
                state_next = ST_LEAN;
            end
            ST_LEAN: begin
                mul_a      = MUL_A_W'(vel_reg);
                mul_b      = B_LEAN;
                state_next = run_reg ? ST_DEN : ST_FINISH;
            end
            ST_DEN: begin
                mul_a      = $signed({{(MUL_A_W-THR_W){1'b0}}, thr_eff});
                mul_b      = B_DEN_SCALE;
                state_next = ST_DB;
            end
            ST_DB: begin
                state_next = ST_AX_KP;
            end
            ST_AX_KP: begin
                mul_a      = MUL_A_W'(kp_sel);
                mul_b      = B_KP_SCALE;
                state_next = ST_AX_KD;
            end
            ST_AX_KD: begin
                mul_a      = MUL_A_W'(kd_sel);
                mul_b      = $signed({{(MUL_B_W-THR_W){1'b0}}, thr_eff});
                state_next = ST_AX_E;
            end
            ST_AX_E: begin
                mul_a      = MUL_A_W'(t1_reg);
                mul_b      = MUL_B_W'(err_sel);
                state_next = ST_AX_R;
            end
            ST_AX_R: begin
                mul_a      = MUL_A_W'(t2_reg);
                mul_b      = MUL_B_W'(rate_sel);
                state_next = ST_AX_SUM;
            end
            ST_AX_SUM: begin
                state_next = ST_AX_DIV;
            end
            ST_AX_DIV: begin
                div_start  = 1'b1;
                state_next = ST_AX_WAIT;
            end
            ST_AX_WAIT: begin
                if (div_done) begin
                    state_next = axis_reg ? ST_FINISH : ST_AX_KP;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            estop_latch_reg <= 1'b0;
            run_reg         <= 1'b0;
            axis_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (state_reg == ST_PR) begin
                estop_latch_reg <= latch_next;
                run_reg         <= balance_enable_reg && !latch_next;
            end
            if (accept) begin
                axis_reg <= 1'b0;
            end else if (state_reg == ST_AX_WAIT && div_done) begin
                axis_reg <= 1'b1;
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            imu_valid_reg <= s_axis_tuser[0];
            pitch_reg     <= s_axis_tdata[16:0];
            roll_reg      <= s_axis_tdata[33:17];
            prate_reg     <= s_axis_tdata[49:34];
            rrate_reg     <= s_axis_tdata[65:50];
            vel_reg       <= s_axis_tdata[81:66];
            // hold zero corrections unless the PD path runs
            cy_reg        <= '0;
            cx_reg        <= '0;
        end
        unique case (state_reg)
            ST_RR:   prd_reg <= rate_round(prod);
            ST_LEAN: rrd_reg <= rate_round(prod);
            ST_DEN: begin
                perr_reg <= {pitch_reg[ANGLE_W-1], pitch_reg, 6'b0} - prod[ERR_W-1:0];
                rerr_reg <= {roll_reg[ANGLE_W-1], roll_reg, 6'b0};
            end
            ST_DB: begin
                den_reg  <= prod[DEN_W-1:0];
                perr_reg <= apply_db(perr_reg, deadband_reg);
                rerr_reg <= apply_db(rerr_reg, deadband_reg);
            end
            ST_AX_KD:  t1_reg  <= prod[KPS_W-1:0];
            ST_AX_E:   t2_reg  <= prod[KDT_W-1:0];
            ST_AX_R:   acc_reg <= prod[NUM_W-1:0];
            ST_AX_SUM: num_reg <= acc_reg + prod[NUM_W-1:0];
            ST_AX_DIV: neg_reg <= num_reg[NUM_W-1];
            ST_AX_WAIT: begin
                if (div_done) begin
                    if (axis_reg) begin
                        cx_reg <= corr;
                    end else begin
                        cy_reg <= corr;
                    end
                end
            end
            default: ;
        endcase
        if (state_reg == ST_FINISH && out_free) begin
            if (imu_valid_reg) begin
                m_data_reg <= {2'b0, cx_reg, cy_reg, roll_reg, prd_reg, pitch_reg};
            end else begin
                m_data_reg <= '0;
            end
            m_user_reg <= {estop_latch_reg, balance_enable_reg, imu_valid_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

[rtl/pdb_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on pdb_pkg for operand and product widths.
module pdb_mul import pdb_pkg::*; (
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

[rtl/pdb_div.sv]
// Restoring divider, one quotient bit per cycle, saturating past QUO_W bits.
// Depends on pdb_pkg for widths.
module pdb_div import pdb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    localparam int CNT_W = $clog2(QUO_W);

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dsh_reg;
    logic [QUO_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ovf_reg;
    logic             ge;

    assign ge = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= NUM_W'(den) << (QUO_W - 1);
            // quotient too large for QUO_W bits: saturate
            ovf_reg <= num >= (NUM_W'(den) << QUO_W);
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[QUO_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quo  = ovf_reg ? {QUO_W{1'b1}} : q_reg;

endmodule

[verif/tb_two_axis_pd_balance_with_estop.sv]
`timescale 1ns / 1ps
// Self-checking testbench for two_axis_pd_balance_with_estop: directed and random IMU items,
// predicted result per item, checked field by field against the result stream.
// Depends on pdb_pkg and the two_axis_pd_balance_with_estop RTL.
module tb_two_axis_pd_balance_with_estop;
    import pdb_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int STALL_CYCLES   = 400;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic                      valid;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [RATE_W-1:0]  prate;
        logic signed [RATE_W-1:0]  rrate;
        logic signed [VEL_W-1:0]   vel;
    } imu_sample_t;

    typedef struct packed {
        logic                      rvalid;
        logic                      en;
        logic                      estop;
        logic signed [ANGLE_W-1:0] pitch_disp;
        logic signed [DPS_W-1:0]   prate_disp;
        logic signed [ANGLE_W-1:0] roll_disp;
        logic signed [CORR_W-1:0]  corr_y;
        logic signed [CORR_W-1:0]  corr_x;
    } balance_result_t;

    typedef struct packed {
        logic                     enable;
        logic [THR_W-1:0]         thr;
        logic [DB_W-1:0]          db;
        logic [CMAX_W-1:0]        cmax;
        logic signed [GAIN_W-1:0] kp_pitch;
        logic signed [GAIN_W-1:0] kd_pitch;
        logic signed [GAIN_W-1:0] kp_roll;
        logic signed [GAIN_W-1:0] kd_roll;
    } ctrl_config_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [87:0]           s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [87:0]           m_axis_tdata;
    logic [2:0]            m_axis_tuser;

    ctrl_config_t    model_cfg;
    logic            estop_model;
    balance_result_t expected_results[$];
    int              mismatch_count = 0;
    int              tx_idle_pct = 35;
    int              rx_idle_pct = 35;
    int              stall_req = 0;
    int              stall_ack = 0;
    int              stall_left = 0;
    int              quiet_cycles = 0;

    two_axis_pd_balance_with_estop dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // nearest, ties away from zero
    function automatic longint round_half_away(longint num, longint den);
        longint q;
        q = (magnitude(num) + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint pd_axis(longint err, longint rate_q8, longint kp, longint kd,
                                       longint thr, longint cmax);
        longint num, den, c;
        num = kp * err * 4 * RATE_REF_DEGS + kd * rate_q8 * thr;
        den = 64 * thr * RATE_REF_DEGS;
        c = -round_half_away(num, den);
        if (c > cmax) c = cmax;
        if (c < -cmax) c = -cmax;
        return c;
    endfunction

    function automatic balance_result_t predict_balance(imu_sample_t smp);
        balance_result_t r;
        longint thr, cmax, db, prd, rrd, ap, ar, perr, rerr, cy, cx;
        r = '0;
        r.en = model_cfg.enable;
        if (!smp.valid) begin
            r.estop = estop_model;
            return r;
        end
        thr  = (model_cfg.thr == 0) ? 1 : longint'(model_cfg.thr);
        cmax = (model_cfg.cmax > CMAX_LIMIT) ? CMAX_LIMIT : longint'(model_cfg.cmax);
        db   = longint'(model_cfg.db) * 64;
        prd  = round_half_away(longint'(smp.prate) * RAD2DEG_Q16, longint'(1) << RATE_SHIFT);
        rrd  = round_half_away(longint'(smp.rrate) * RAD2DEG_Q16, longint'(1) << RATE_SHIFT);
        ap   = magnitude(longint'(smp.pitch));
        ar   = magnitude(longint'(smp.roll));
        if (ap > thr || ar > thr)
            estop_model = 1'b1;
        // release only below 80% of the threshold on both axes
        if (estop_model && 5 * ap < 4 * thr && 5 * ar < 4 * thr)
            estop_model = 1'b0;
        cy = 0;
        cx = 0;
        if (model_cfg.enable && !estop_model) begin
            perr = longint'(smp.pitch) * 64 - longint'(smp.vel) * LEAN_DEG_PER_UNIT;
            rerr = longint'(smp.roll) * 64;
            if (magnitude(perr) < db) perr = 0;
            if (magnitude(rerr) < db) rerr = 0;
            cy = pd_axis(perr, prd, model_cfg.kp_pitch, model_cfg.kd_pitch, thr, cmax);
            cx = pd_axis(rerr, rrd, model_cfg.kp_roll, model_cfg.kd_roll, thr, cmax);
        end
        r.rvalid     = 1'b1;
        r.estop      = estop_model;
        r.pitch_disp = smp.pitch;
        r.prate_disp = DPS_W'(prd);
        r.roll_disp  = smp.roll;
        r.corr_y     = CORR_W'(cy);
        r.corr_x     = CORR_W'(cx);
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_BALANCE_ENABLE:  model_cfg.enable   = val[0];
            REG_ESTOP_THRESHOLD: model_cfg.thr      = val[THR_W-1:0];
            REG_DEADBAND:        model_cfg.db       = val[DB_W-1:0];
            REG_CORRECTION_MAX:  model_cfg.cmax     = val[CMAX_W-1:0];
            REG_KP_PITCH:        model_cfg.kp_pitch = val;
            REG_KD_PITCH:        model_cfg.kd_pitch = val;
            REG_KP_ROLL:         model_cfg.kp_roll  = val;
            REG_KD_ROLL:         model_cfg.kd_roll  = val;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    // call only with the block idle
    task automatic load_config(input ctrl_config_t c);
        write_reg(REG_BALANCE_ENABLE,  CFG_DATA_W'(c.enable));
        write_reg(REG_ESTOP_THRESHOLD, CFG_DATA_W'(c.thr));
        write_reg(REG_DEADBAND,        CFG_DATA_W'(c.db));
        write_reg(REG_CORRECTION_MAX,  CFG_DATA_W'(c.cmax));
        write_reg(REG_KP_PITCH,        c.kp_pitch);
        write_reg(REG_KD_PITCH,        c.kd_pitch);
        write_reg(REG_KP_ROLL,         c.kp_roll);
        write_reg(REG_KD_ROLL,         c.kd_roll);
        cfg_valid <= 1'b0;
    endtask

    // leaves tvalid high on return; settle_outputs drops it
    task automatic send_imu_sample(input imu_sample_t smp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= smp.valid;
        s_axis_tdata  <= {6'b0, smp.vel, smp.rrate, smp.prate, smp.roll, smp.pitch};
        do @(posedge aclk); while (!s_axis_tready);
        expected_results.push_back(predict_balance(smp));
    endtask

    task automatic settle_outputs();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic imu_sample_t make_sample(bit v, int p, int r, int pr, int rr, int vel);
        imu_sample_t s;
        s.valid = v;
        s.pitch = ANGLE_W'(p);
        s.roll  = ANGLE_W'(r);
        s.prate = RATE_W'(pr);
        s.rrate = RATE_W'(rr);
        s.vel   = VEL_W'(vel);
        return s;
    endfunction

    function automatic ctrl_config_t make_config(bit en, int thr, int db, int cmax,
                                                 int kpp, int kdp, int kpr, int kdr);
        ctrl_config_t c;
        c.enable   = en;
        c.thr      = THR_W'(thr);
        c.db       = DB_W'(db);
        c.cmax     = CMAX_W'(cmax);
        c.kp_pitch = GAIN_W'(kpp);
        c.kd_pitch = GAIN_W'(kdp);
        c.kp_roll  = GAIN_W'(kpr);
        c.kd_roll  = GAIN_W'(kdr);
        return c;
    endfunction

    // angles cluster around the threshold so the latch sets and clears often
    function automatic int pick_angle(int thr, int db);
        int span, mag;
        span = thr * 5 / 4 + 1;
        if (span > 46080) span = 46080;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: mag = $urandom_range(0, span);
            7:       mag = $urandom_range(0, db * 2 + 1);
            default: mag = $urandom_range(0, 46080);
        endcase
        if (mag > 46080) mag = 46080;
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic ctrl_config_t random_config();
        int thr, cmax;
        case ($urandom_range(3))
            0:       thr = $urandom_range(1, 46080);
            1:       thr = $urandom_range(256, 2560);
            2:       thr = 7680;
            default: thr = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 1 : 46080);
        endcase
        cmax = ($urandom_range(9) == 0) ? $urandom_range(16385, 32767) : $urandom_range(0, 16384);
        return make_config($urandom_range(99) < 80, thr, $urandom_range(0, 2560), cmax,
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
    endfunction

    // ---------------------------------------------------------------- receiver and checker

    always @(posedge aclk) begin
        if (stall_req != stall_ack) begin
            stall_ack     <= stall_req;
            stall_left    <= STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        balance_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.rvalid     = m_axis_tuser[0];
            got.en         = m_axis_tuser[1];
            got.estop      = m_axis_tuser[2];
            got.pitch_disp = m_axis_tdata[16:0];
            got.prate_disp = m_axis_tdata[36:17];
            got.roll_disp  = m_axis_tdata[53:37];
            got.corr_y     = m_axis_tdata[69:54];
            got.corr_x     = m_axis_tdata[85:70];
            if (expected_results.size() == 0) begin
                $error("result item with none expected");
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("result_valid", want.rvalid, got.rvalid);
                check_field("enabled_flag", want.en, got.en);
                check_field("estop_flag", want.estop, got.estop);
                check_field("pitch_display", want.pitch_disp, got.pitch_disp);
                check_field("pitch_rate_display", want.prate_disp, got.prate_disp);
                check_field("roll_display", want.roll_disp, got.roll_disp);
                check_field("correction_y", want.corr_y, got.corr_y);
                check_field("correction_x", want.corr_x, got.corr_x);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_two_axis_pd_balance_with_estop NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // defaults: disabled, threshold 30 deg; the latch must still work
    task automatic test_reset_defaults();
        send_imu_sample(make_sample(1, 100, -100, 500, -500, 0));
        send_imu_sample(make_sample(1, 7681, 0, 0, 0, 0));
        send_imu_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_imu_sample(make_sample(1, 0, 0, 0, 0, 0));
        settle_outputs();
    endtask

    task automatic test_latch_and_deadband();
        load_config(make_config(1, 7680, 256, 16384, 4096, 2048, -4096, 32767));
        send_imu_sample(make_sample(1, 0, 0, 0, 0, 0));
        // deadband edge: 256 kept, 255 zeroed
        send_imu_sample(make_sample(1, 256, -255, 32767, -32768, 16384));
        send_imu_sample(make_sample(1, -256, 255, -32768, 32767, -16384));
        send_imu_sample(make_sample(1, 7000, -7000, 1000, -1000, 0));
        send_imu_sample(make_sample(1, 7681, 0, 0, 0, 0));
        // invalid item holds the latch
        send_imu_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_imu_sample(make_sample(1, 6144, 0, 0, 0, 0));
        send_imu_sample(make_sample(1, 6143, -6143, 0, 0, 0));
        send_imu_sample(make_sample(1, 0, -7681, 0, 0, 0));
        send_imu_sample(make_sample(1, 46080, -46080, 32767, 32767, 16384));
        send_imu_sample(make_sample(1, -46080, 46080, -32768, -32768, -16384));
        send_imu_sample(make_sample(1, 0, 0, 0, 0, 0));
        send_imu_sample(make_sample(0, 46080, 46080, 32767, 32767, 16384));
        send_imu_sample(make_sample(1, 1000, 1000, -12345, 23456, 5000));
        settle_outputs();
    endtask

    task automatic test_register_extremes();
        // zero threshold acts as one; oversized clamp acts as CMAX_LIMIT
        load_config(make_config(1, 0, 0, 32767, 32767, -32768, -32768, 32767));
        send_imu_sample(make_sample(1, 0, 0, 32767, -32768, 0));
        send_imu_sample(make_sample(1, 1, -1, -1, 1, 0));
        send_imu_sample(make_sample(1, 2, 0, 0, 0, 0));
        send_imu_sample(make_sample(1, 0, 0, 0, 0, 0));
        settle_outputs();
        // half-way quotients round away from zero
        load_config(make_config(1, 32768, 0, 16384, 4096, 0, -4096, 0));
        send_imu_sample(make_sample(1, 3, -3, 0, 0, 0));
        send_imu_sample(make_sample(1, -3, 3, 0, 0, 0));
        settle_outputs();
        load_config(make_config(1, 46080, 2560, 0, -32768, -32768, -32768, -32768));
        send_imu_sample(make_sample(1, 46080, -2560, 32767, -32768, 0));
        send_imu_sample(make_sample(1, 2559, 2560, 100, -100, 0));
        settle_outputs();
    endtask

    // hold the result side off long enough for the input to back up
    task automatic test_output_backpressure();
        load_config(make_config(1, 7680, 256, 11469, 4096, 4096, 4096, 4096));
        tx_idle_pct = 0;
        stall_req <= stall_req + 1;
        repeat (30)
            send_imu_sample(make_sample($urandom_range(99) < 90, pick_angle(7680, 256),
                                        pick_angle(7680, 256), $urandom_range(0, 65535),
                                        $urandom_range(0, 65535),
                                        int'($urandom_range(0, 32768)) - 16384));
        settle_outputs();
        tx_idle_pct = 35;
    endtask

    task automatic test_random_flight();
        ctrl_config_t c;
        int thr;
        for (int ph = 0; ph < 7; ph++) begin
            c = random_config();
            load_config(c);
            thr = (c.thr == 0) ? 1 : int'(c.thr);
            // one phase without any idling on either side
            tx_idle_pct = (ph == 3) ? 0 : 35;
            rx_idle_pct = (ph == 3) ? 0 : 35;
            repeat (100)
                send_imu_sample(make_sample($urandom_range(99) < 88, pick_angle(thr, c.db),
                                            pick_angle(thr, c.db), $urandom_range(0, 65535),
                                            $urandom_range(0, 65535),
                                            int'($urandom_range(0, 32768)) - 16384));
            settle_outputs();
        end
        tx_idle_pct = 35;
        rx_idle_pct = 35;
    endtask

    initial begin
        model_cfg   = make_config(0, 7680, 256, 11469, 0, 0, 0, 0);
        estop_model = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_latch_and_deadband();
        test_register_extremes();
        test_output_backpressure();
        test_random_flight();

        // catch stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_two_axis_pd_balance_with_estop OK");
        else
            $display("tb_two_axis_pd_balance_with_estop NOT OK");
        $finish;
    end

endmodule
